@@ hdl/s1kt_pkg.sv @@
// ----------------------------------------------------------------------------
// s1kt_pkg
// Shared types, scancodes and the key code ROM for the set-1 key translator.
// ----------------------------------------------------------------------------
package s1kt_pkg;

  localparam int unsigned ConsoleCountDefault = 12;

  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_KEY     = 3'd1,
    KIND_CONSOLE = 3'd2,
    KIND_LEDS    = 3'd3,
    KIND_REBOOT  = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] key_code;
    logic [3:0] console_index;
    logic [2:0] led_bits;
  } result_t;

  // modifier flag bit positions
  localparam int unsigned FlagAlt    = 0;
  localparam int unsigned FlagCtrl   = 1;
  localparam int unsigned FlagShift  = 2;
  localparam int unsigned FlagScroll = 3;
  localparam int unsigned FlagNum    = 4;
  localparam int unsigned FlagCaps   = 5;

  typedef logic [5:0] flags_t;

  localparam logic [7:0] ScRelease  = 8'h80;
  localparam logic [7:0] ScCtrl     = 8'h1D;
  localparam logic [7:0] ScLShift   = 8'h2A;
  localparam logic [7:0] ScRShift   = 8'h36;
  localparam logic [7:0] ScAlt      = 8'h38;
  localparam logic [7:0] ScCaps     = 8'h3A;
  localparam logic [7:0] ScF1       = 8'h3B;
  localparam logic [7:0] ScF10      = 8'h44;
  localparam logic [7:0] ScNum      = 8'h45;
  localparam logic [7:0] ScScroll   = 8'h46;
  localparam logic [7:0] ScF11      = 8'h57;
  localparam logic [7:0] ScF12      = 8'h58;

  localparam logic [7:0] KcDel      = 8'h91;

  function automatic logic [7:0] key_rom(input logic [7:0] code);
    logic [7:0] k;
    case (code)
      8'h01: k = 8'h1B;  8'h02: k = 8'h31;  8'h03: k = 8'h32;  8'h04: k = 8'h33;
      8'h05: k = 8'h34;  8'h06: k = 8'h35;  8'h07: k = 8'h36;  8'h08: k = 8'h37;
      8'h09: k = 8'h38;  8'h0A: k = 8'h39;  8'h0B: k = 8'h30;  8'h0C: k = 8'h2D;
      8'h0D: k = 8'h3D;  8'h0E: k = 8'h08;  8'h0F: k = 8'h09;
      8'h10: k = 8'h71;  8'h11: k = 8'h77;  8'h12: k = 8'h65;  8'h13: k = 8'h72;
      8'h14: k = 8'h74;  8'h15: k = 8'h79;  8'h16: k = 8'h75;  8'h17: k = 8'h69;
      8'h18: k = 8'h6F;  8'h19: k = 8'h70;  8'h1A: k = 8'h5B;  8'h1B: k = 8'h5D;
      8'h1C: k = 8'h0A;  8'h1E: k = 8'h61;  8'h1F: k = 8'h73;
      8'h20: k = 8'h64;  8'h21: k = 8'h66;  8'h22: k = 8'h67;  8'h23: k = 8'h68;
      8'h24: k = 8'h6A;  8'h25: k = 8'h6B;  8'h26: k = 8'h6C;  8'h27: k = 8'h3B;
      8'h28: k = 8'h27;  8'h29: k = 8'h60;  8'h2B: k = 8'h5C;  8'h2C: k = 8'h7A;
      8'h2D: k = 8'h78;  8'h2E: k = 8'h63;  8'h2F: k = 8'h76;
      8'h30: k = 8'h62;  8'h31: k = 8'h6E;  8'h32: k = 8'h6D;  8'h33: k = 8'h2C;
      8'h34: k = 8'h2E;  8'h35: k = 8'h2F;  8'h39: k = 8'h20;
      8'h3B: k = 8'h80;  8'h3C: k = 8'h81;  8'h3D: k = 8'h82;  8'h3E: k = 8'h83;
      8'h3F: k = 8'h84;  8'h40: k = 8'h85;  8'h41: k = 8'h86;  8'h42: k = 8'h87;
      8'h43: k = 8'h88;  8'h44: k = 8'h89;
      8'h47: k = 8'h92;  8'h48: k = 8'h97;  8'h49: k = 8'h94;  8'h4A: k = 8'h2D;
      8'h4B: k = 8'h96;  8'h4C: k = 8'h35;  8'h4D: k = 8'h99;  8'h4E: k = 8'h2B;
      8'h4F: k = 8'h93;  8'h50: k = 8'h98;  8'h51: k = 8'h95;  8'h52: k = 8'h90;
      8'h53: k = 8'h91;  8'h57: k = 8'h8A;  8'h58: k = 8'h8B;
      default: k = 8'h00;
    endcase
    return k;
  endfunction

endpackage

@@ hdl/scancode_set1_key_translator.sv @@
// ----------------------------------------------------------------------------
// scancode_set1_key_translator
// Translates raw set-1 scancode bytes into key codes, console selects,
// LED updates and reboot requests, one result per byte.
//
//   channel | signals                                        | direction
//   --------+------------------------------------------------+----------
//   in      | in_valid_i, in_ready_o, scancode_i             | sink
//   out     | out_valid_o, out_ready_i, kind_o, key_code_o,  | source
//           | console_index_o, led_bits_o                    |
//
// One beat per cycle while the output is not stalled; each beat passes the
// input register, decode and the result register.
// Reset clears both stage valids and all modifier flags.
// A stalled output holds its beat; the input register keeps filling, so
// in_ready_o drops only when both stages are full and the output is stalled.
// ----------------------------------------------------------------------------
module scancode_set1_key_translator #(
  parameter int unsigned CONSOLE_COUNT = s1kt_pkg::ConsoleCountDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] scancode_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] kind_o,
  output logic [7:0] key_code_o,
  output logic [3:0] console_index_o,
  output logic [1+1:0] led_bits_o
);
  import s1kt_pkg::*;

  logic       code_valid_q;
  logic [7:0] code_q;
  logic       res_valid_q;
  result_t    res_q;
  result_t    res_d;
  flags_t     flags_q;
  flags_t     flags_d;
  logic       advance;

  assign advance    = !res_valid_q || out_ready_i;
  assign in_ready_o = !code_valid_q || advance;

  s1kt_decode #(
    .CONSOLE_COUNT(CONSOLE_COUNT)
  ) u_decode (
    .code_i  (code_q),
    .flags_i (flags_q),
    .flags_o (flags_d),
    .result_o(res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
      flags_q      <= '0;
    end else begin
      if (in_ready_o) begin
        code_valid_q <= in_valid_i;
      end
      if (advance) begin
        res_valid_q <= code_valid_q;
        if (code_valid_q) begin
          flags_q <= flags_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      code_q <= scancode_i;
    end
    if (advance && code_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = res_valid_q;
  assign kind_o          = res_q.kind;
  assign key_code_o      = res_q.key_code;
  assign console_index_o = res_q.console_index;
  assign led_bits_o      = res_q.led_bits;

endmodule

@@ hdl/s1kt_decode.sv @@
// ----------------------------------------------------------------------------
// s1kt_decode
// Decodes one scancode against the modifier flags into a result and the
// updated flags.
// ----------------------------------------------------------------------------
module s1kt_decode #(
  parameter int unsigned CONSOLE_COUNT = s1kt_pkg::ConsoleCountDefault
) (
  input  logic [7:0]       code_i,
  input  s1kt_pkg::flags_t flags_i,
  output s1kt_pkg::flags_t flags_o,
  output s1kt_pkg::result_t result_o
);
  import s1kt_pkg::*;

  logic       is_fkey;
  logic [3:0] con;
  logic [7:0] base;
  flags_t     mod;
  flags_t     tog;
  flags_t     nxt;
  logic [7:0] key;

  always_comb begin
    is_fkey = 1'b1;
    con     = 4'd0;
    if (code_i inside {[ScF1:ScF10]}) begin
      con = 4'(code_i - ScF1);
    end else if (code_i == ScF11) begin
      con = 4'd10;
    end else if (code_i == ScF12) begin
      con = 4'd11;
    end else begin
      is_fkey = 1'b0;
    end
  end

  always_comb begin
    base = {1'b0, code_i[6:0]};
    mod  = '0;
    case (base)
      ScAlt:              mod[FlagAlt]   = 1'b1;
      ScCtrl:             mod[FlagCtrl]  = 1'b1;
      ScLShift, ScRShift: mod[FlagShift] = 1'b1;
      default:            mod = '0;
    endcase
  end

  always_comb begin
    tog = '0;
    case (code_i)
      ScScroll: tog[FlagScroll] = 1'b1;
      ScNum:    tog[FlagNum]    = 1'b1;
      ScCaps:   tog[FlagCaps]   = 1'b1;
      default:  tog = '0;
    endcase
  end

  assign key = key_rom(code_i);

  always_comb begin
    result_o = '{kind: KIND_NONE, key_code: 8'h00, console_index: 4'd0, led_bits: 3'd0};
    nxt      = flags_i;
    if (is_fkey) begin
      if ({1'b0, con} < 5'(CONSOLE_COUNT)) begin
        result_o.kind          = KIND_CONSOLE;
        result_o.console_index = con;
      end
    end else if (code_i >= ScRelease) begin
      nxt = flags_i & ~mod;
    end else if (mod != '0) begin
      nxt = flags_i | mod;
    end else if (tog != '0) begin
      nxt               = flags_i ^ tog;
      result_o.kind     = KIND_LEDS;
      result_o.led_bits = {nxt[FlagCaps], nxt[FlagNum], nxt[FlagScroll]};
    end else if (key != 8'h00) begin
      if (flags_i[FlagCtrl] && flags_i[FlagAlt] && key == KcDel) begin
        result_o.kind = KIND_REBOOT;
      end else begin
        result_o.kind     = KIND_KEY;
        result_o.key_code = key;
      end
    end
  end

  assign flags_o = nxt;

endmodule
